/* src/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define MAU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/mau_pkg.sv */
package mau_pkg;

  localparam int unsigned DATA_W = 30;
  localparam int unsigned EXP_BITS = 30;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [29:0] FIELD_PRIME = 30'd998244353;
  localparam logic [31:0] PRIME32 = 32'd998244353;
  localparam logic [31:0] TWO_PRIME32 = 32'd1996488706;
  localparam logic [29:0] INV_EXP = 30'd998244351;

  // floor(2^60 / p), fits in 31 bits
  localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / 64'd998244353);

  typedef struct packed {
    logic        vld;
    logic [1:0]  op;
    logic [29:0] a;
    logic [29:0] b;
  } item_t;

endpackage

/* src/mau_modmul.sv */
module mau_modmul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [29:0]         x,
  input  logic [29:0]         y,
  input  mau_pkg::item_t      side_i,
  output logic [29:0]         z,
  output mau_pkg::item_t      side_o
);

  logic [59:0] p_r, p_nxt;
  logic [30:0] q_r, q_nxt;
  logic [31:0] pl_r;
  logic [31:0] r_r, r_nxt;
  logic [29:0] z_r, z_nxt;
  logic [61:0] qm;
  logic [60:0] qp;
  logic [31:0] r_m1, r_m2;
  mau_pkg::item_t side_r [0:3];

  assign p_nxt = {30'b0, x} * {30'b0, y};
  // barrett estimate, at most two short of the true quotient
  assign qm    = {31'b0, p_r[59:29]} * {31'b0, mau_pkg::BARRETT_M};
  assign q_nxt = qm[61:31];
  assign qp    = {30'b0, q_r} * {31'b0, mau_pkg::FIELD_PRIME};
  assign r_nxt = pl_r - qp[31:0];
  assign r_m1  = r_r - mau_pkg::PRIME32;
  assign r_m2  = r_r - mau_pkg::TWO_PRIME32;

  always_comb begin
    if (r_r >= mau_pkg::TWO_PRIME32) begin
      z_nxt = r_m2[29:0];
    end else if (r_r >= mau_pkg::PRIME32) begin
      z_nxt = r_m1[29:0];
    end else begin
      z_nxt = r_r[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= p_nxt;
      q_r  <= q_nxt;
      pl_r <= p_r[31:0];
      r_r  <= r_nxt;
      z_r  <= z_nxt;
      side_r[0] <= side_i;
      side_r[1] <= side_r[0];
      side_r[2] <= side_r[1];
      side_r[3] <= side_r[2];
    end
    if (!rst_n) begin
      side_r[0].vld <= 1'b0;
      side_r[1].vld <= 1'b0;
      side_r[2].vld <= 1'b0;
      side_r[3].vld <= 1'b0;
    end
  end

  assign z      = z_r;
  assign side_o = side_r[3];

endmodule

/* src/mau_pow_step.sv */
module mau_pow_step #(
  parameter logic EXP_BIT = 1'b1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [29:0]    sq_i,
  input  logic [29:0]    acc_i,
  input  mau_pkg::item_t side_i,
  output logic [29:0]    sq_o,
  output logic [29:0]    acc_o,
  output mau_pkg::item_t side_o
);

  logic [29:0] acc_y;

  // multiply in the square only where the exponent bit is set
  assign acc_y = EXP_BIT ? sq_i : 30'd1;

  mau_modmul u_sq (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .x      (sq_i),
    .y      (sq_i),
    .side_i (side_i),
    .z      (sq_o),
    .side_o (side_o)
  );

  mau_modmul u_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .x      (acc_i),
    .y      (acc_y),
    .side_i ('0),
    .z      (acc_o),
    .side_o ()
  );

endmodule

/* src/modular_arith_unit.sv */
// Modular arithmetic unit over GF(998244353). Each item carries an opcode
// (add, subtract, multiply, divide) and two 30-bit operands, which are first
// reduced modulo the prime. One item may enter every cycle unless the pipeline
// is held, and every item gives one result after passing an operand reduction
// register, thirty four-stage square-and-multiply steps that raise the divisor
// to p-2, a final four-stage barrett multiplier and the output register. The
// whole pipeline advances together and holds while a result waits to be taken.
// A zero divisor gives a quotient of 0.
module modular_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [29:0] in_operand_a,
  input  logic [29:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] out_result
);

  logic en;
  logic [29:0] a_red, b_red;
  mau_pkg::item_t it0_r;
  logic [29:0] sq_w [0:mau_pkg::EXP_BITS];
  logic [29:0] acc_w [0:mau_pkg::EXP_BITS];
  mau_pkg::item_t it_w [0:mau_pkg::EXP_BITS];
  logic [29:0] mul_y, prod;
  mau_pkg::item_t fin;
  logic [30:0] sum;
  logic [29:0] diff;
  logic out_valid_r;
  logic [29:0] out_result_r, out_result_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign a_red = (in_operand_a >= mau_pkg::FIELD_PRIME) ?
                 in_operand_a - mau_pkg::FIELD_PRIME : in_operand_a;
  assign b_red = (in_operand_b >= mau_pkg::FIELD_PRIME) ?
                 in_operand_b - mau_pkg::FIELD_PRIME : in_operand_b;

  always_ff @(posedge clk) begin
    if (en) begin
      it0_r.vld <= in_valid;
      it0_r.op  <= in_opcode;
      it0_r.a   <= a_red;
      it0_r.b   <= b_red;
    end
    if (!rst_n) begin
      it0_r.vld <= 1'b0;
    end
  end

  assign sq_w[0]  = it0_r.b;
  assign acc_w[0] = 30'd1;
  assign it_w[0]  = it0_r;

  for (genvar i = 0; i < mau_pkg::EXP_BITS; i++) begin : g_step
    mau_pow_step #(
      .EXP_BIT (mau_pkg::INV_EXP[i])
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .sq_i   (sq_w[i]),
      .acc_i  (acc_w[i]),
      .side_i (it_w[i]),
      .sq_o   (sq_w[i+1]),
      .acc_o  (acc_w[i+1]),
      .side_o (it_w[i+1])
    );
  end

  assign mul_y = (it_w[mau_pkg::EXP_BITS].op == mau_pkg::OP_DIV) ?
                 acc_w[mau_pkg::EXP_BITS] : it_w[mau_pkg::EXP_BITS].b;

  mau_modmul u_final (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .x      (it_w[mau_pkg::EXP_BITS].a),
    .y      (mul_y),
    .side_i (it_w[mau_pkg::EXP_BITS]),
    .z      (prod),
    .side_o (fin)
  );

  assign sum  = {1'b0, fin.a} + {1'b0, fin.b};
  // wraps modulo 2^30, true value stays below p
  assign diff = (fin.a >= fin.b) ? fin.a - fin.b : fin.a + mau_pkg::FIELD_PRIME - fin.b;

  always_comb begin
    case (fin.op)
      mau_pkg::OP_ADD: begin
        out_result_nxt = (sum >= {1'b0, mau_pkg::FIELD_PRIME}) ?
                         30'(sum - {1'b0, mau_pkg::FIELD_PRIME}) : sum[29:0];
      end
      mau_pkg::OP_SUB: out_result_nxt = diff;
      default:         out_result_nxt = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_valid_r  <= fin.vld;
      out_result_r <= out_result_nxt;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

/* src/mau_checker.sv */
`include "assert_macros.svh"

module mau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [29:0] out_result
);

  `MAU_ASSERT(a_result_reduced, clk, rst_n, out_valid |-> (out_result < mau_pkg::FIELD_PRIME), "result not reduced")
  `MAU_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "not ready with empty output")
  `MAU_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_result)), "stalled item changed")
  `MAU_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind modular_arith_unit mau_checker u_mau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_result (out_result)
);
